// ===== sv/scpr_pkg.sv =====
`default_nettype none
package scpr_pkg;

  // Port field widths.
  localparam int unsigned PAGE_W     = 16;
  localparam int unsigned FRAME_W    = 4;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CFG_W      = 5;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_FRAMES_DEFAULT = 16;
  localparam int unsigned PAGE_BITS_DEFAULT  = 16;

  // Reset value of the managed frame count register.
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

endpackage
`default_nettype wire

// ===== sv/scpr_if.sv =====
`default_nettype none
// Reference request channel.
interface scpr_in_if;
  logic                        valid;
  logic                        ready;
  logic [scpr_pkg::PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

// Result channel.
interface scpr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         replaced;
  logic [scpr_pkg::PAGE_W-1:0]  victim_page;
  logic [scpr_pkg::FRAME_W-1:0] frame_index;
  logic [scpr_pkg::COUNT_W-1:0] replacement_count;

  modport source (output valid, output hit, output replaced, output victim_page,
                  output frame_index, output replacement_count, input ready);
  modport sink   (input valid, input hit, input replaced, input victim_page,
                  input frame_index, input replacement_count, output ready);
endinterface
`default_nettype wire

// ===== sv/scpr_ram.sv =====
`default_nettype none
// Simple dual-port RAM: one write port, one read port with registered data.
module scpr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/second_chance_page_replacement_core.sv =====
// Second-chance (clock) page replacement engine. Each transfer on the input
// channel carries one page reference and produces exactly one transfer on the
// output channel: hit, replaced, the evicted page, the frame now holding the
// page and the saturating replacement count. Resident page numbers live in a
// single synchronous RAM; reference bits, the clock hand and the fill count
// are flip-flops. One reference is handled at a time. A lookup streams the
// resident frames out of the RAM, one per cycle, and stops at the first hit.
// A miss with every frame in use then walks the hand over the reference
// bits, one frame per cycle and at most n + 1 frames, where n is the
// managed frame count, and then reads the victim and writes the new page.
// A new reference is taken while the previous result still waits at the
// output. Writing the frame count register flushes all frames (fill count,
// hand and reference bits) but keeps the replacement count; it must only be
// written while the block is idle. No clearing pass is needed after reset.
`default_nettype none
module second_chance_page_replacement_core #(
  parameter int unsigned MAX_FRAMES = scpr_pkg::MAX_FRAMES_DEFAULT,
  parameter int unsigned PAGE_BITS  = scpr_pkg::PAGE_BITS_DEFAULT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [scpr_pkg::CFG_W-1:0]  cfg_wdata_i,
  scpr_in_if.sink                          in_if,
  scpr_out_if.source                       out_if
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_VRD   = 3'd3;
  localparam logic [2:0] ST_VWR   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]                      state_q;
  logic [scpr_pkg::CFG_W-1:0]      cfg_q;
  logic [MAX_FRAMES-1:0]           ref_q;
  logic [IDX_W-1:0]                hand_q;
  logic [CNT_W-1:0]                filled_q;
  logic [scpr_pkg::COUNT_W-1:0]    count_q;

  // Per-reference working registers.
  logic [PAGE_BITS-1:0]            page_q;
  logic [CNT_W-1:0]                resident_q;
  logic [CNT_W-1:0]                issue_q;
  logic                            cmp_pend_q;
  logic [IDX_W-1:0]                cmp_idx_q;
  logic [IDX_W-1:0]                h_q;
  logic                            res_hit_q;
  logic                            res_rep_q;
  logic [PAGE_BITS-1:0]            res_victim_q;
  logic [IDX_W-1:0]                res_frame_q;

  // Output register.
  logic                            out_valid_q;
  logic                            out_hit_q;
  logic                            out_rep_q;
  logic [scpr_pkg::PAGE_W-1:0]     out_victim_q;
  logic [scpr_pkg::FRAME_W-1:0]    out_frame_q;
  logic [scpr_pkg::COUNT_W-1:0]    out_count_q;

  logic [CNT_W-1:0]                n_frames;
  logic [CNT_W-1:0]                resident;
  logic [IDX_W-1:0]                hand_start;
  logic [IDX_W-1:0]                h_next;
  logic                            issuing;
  logic                            match;
  logic                            scan_done;
  logic                            in_xfer;

  logic                            ram_we;
  logic [IDX_W-1:0]                ram_waddr;
  logic [IDX_W-1:0]                ram_raddr;
  logic [PAGE_BITS-1:0]            ram_rdata;

  // A frame count of zero acts as one, any count above the frame parameter as the maximum.
  always_comb begin
    if (cfg_q == '0) begin
      n_frames = CNT_W'(1);
    end else if (32'(cfg_q) > 32'(MAX_FRAMES)) begin
      n_frames = CNT_W'(MAX_FRAMES);
    end else begin
      n_frames = CNT_W'(cfg_q);
    end
  end

  assign resident   = (filled_q < n_frames) ? filled_q : n_frames;
  assign hand_start = (CNT_W'(hand_q) < n_frames) ? hand_q : '0;
  assign h_next     = ((CNT_W'(h_q) + CNT_W'(1)) == n_frames) ? '0 : h_q + IDX_W'(1);

  // The scan issues one RAM read per cycle and compares the returned data in the cycle after the read.
  assign issuing   = issue_q < resident_q;
  assign match     = cmp_pend_q && (ram_rdata == page_q);
  assign scan_done = !issuing && !cmp_pend_q;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = h_q;
    ram_raddr = issue_q[IDX_W-1:0];
    case (state_q)
      ST_SCAN: begin
        if (!match && scan_done && (resident_q < n_frames)) begin
          ram_we    = 1'b1;
          ram_waddr = resident_q[IDX_W-1:0];
        end
      end
      ST_VRD: begin
        ram_raddr = h_q;
      end
      ST_VWR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  scpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (page_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control and frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= scpr_pkg::FRAMES_RESET;
      ref_q       <= '0;
      hand_q      <= '0;
      filled_q    <= '0;
      count_q     <= '0;
      cmp_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
    end else begin
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        // A write flushes every frame; the replacement count survives.
        cfg_q    <= cfg_wdata_i;
        ref_q    <= '0;
        hand_q   <= '0;
        filled_q <= '0;
      end
      case (state_q)
        ST_IDLE: begin
          cmp_pend_q <= 1'b0;
          if (in_xfer) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_pend_q <= issuing && !match;
          if (match) begin
            ref_q[cmp_idx_q] <= 1'b1;
            state_q          <= ST_FIN;
          end else if (scan_done) begin
            if (resident_q < n_frames) begin
              ref_q[resident_q[IDX_W-1:0]] <= 1'b0;
              filled_q                     <= resident_q + CNT_W'(1);
              state_q                      <= ST_FIN;
            end else begin
              state_q <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          // Give each referenced frame its second chance on the way past.
          if (ref_q[h_q]) begin
            ref_q[h_q] <= 1'b0;
          end else begin
            state_q <= ST_VRD;
          end
        end
        ST_VRD: begin
          state_q <= ST_VWR;
        end
        ST_VWR: begin
          ref_q[h_q] <= 1'b0;
          hand_q     <= h_next;
          if (count_q != '1) begin
            count_q <= count_q + scpr_pkg::COUNT_W'(1);
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_if.ready) begin
            // The count is captured with the result so that a later
            // reference cannot change it while the result waits.
            out_valid_q <= 1'b1;
            out_count_q <= count_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        page_q     <= PAGE_BITS'(in_if.page);
        resident_q <= resident;
        issue_q    <= '0;
      end
      ST_SCAN: begin
        if (issuing) begin
          issue_q <= issue_q + CNT_W'(1);
        end
        cmp_idx_q <= issue_q[IDX_W-1:0];
        h_q       <= hand_start;
        if (match) begin
          res_hit_q    <= 1'b1;
          res_rep_q    <= 1'b0;
          res_victim_q <= '0;
          res_frame_q  <= cmp_idx_q;
        end else if (scan_done) begin
          res_hit_q    <= 1'b0;
          res_rep_q    <= 1'b0;
          res_victim_q <= '0;
          res_frame_q  <= resident_q[IDX_W-1:0];
        end
      end
      ST_SWEEP: begin
        if (ref_q[h_q]) begin
          h_q <= h_next;
        end
      end
      ST_VWR: begin
        res_hit_q    <= 1'b0;
        res_rep_q    <= 1'b1;
        res_victim_q <= ram_rdata;
        res_frame_q  <= h_q;
      end
      ST_FIN: begin
        if (!out_valid_q || out_if.ready) begin
          out_hit_q    <= res_hit_q;
          out_rep_q    <= res_rep_q;
          out_victim_q <= scpr_pkg::PAGE_W'(res_victim_q);
          out_frame_q  <= scpr_pkg::FRAME_W'(res_frame_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.hit               = out_hit_q;
  assign out_if.replaced          = out_rep_q;
  assign out_if.victim_page       = out_victim_q;
  assign out_if.frame_index       = out_frame_q;
  assign out_if.replacement_count = out_count_q;

endmodule
`default_nettype wire

// ===== sv/scpr_checker.sv =====
`default_nettype none
module scpr_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic                         hit_i,
  input wire logic                         replaced_i,
  input wire logic [scpr_pkg::PAGE_W-1:0]  victim_page_i,
  input wire logic [scpr_pkg::COUNT_W-1:0] replacement_count_i
);

  // A result waiting at the output stays until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // One reference is in work at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second reference taken while one is in work");

  a_hit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(hit_i && replaced_i))
    else $error("hit and replacement reported together");

  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !replaced_i |-> victim_page_i == '0)
    else $error("victim page reported without a replacement");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(replacement_count_i == '1) || replacement_count_i == '1)
    else $error("saturated replacement count moved");

endmodule

bind second_chance_page_replacement_core scpr_checker u_scpr_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_if.valid),
  .in_ready_i          (in_if.ready),
  .out_valid_i         (out_if.valid),
  .out_ready_i         (out_if.ready),
  .hit_i               (out_if.hit),
  .replaced_i          (out_if.replaced),
  .victim_page_i       (out_if.victim_page),
  .replacement_count_i (out_if.replacement_count)
);
`default_nettype wire
